// ===== rtl/scf_pkg.sv =====
// Package: shared types, codes and checksum helper for the command framer.
package scf_pkg;

  localparam int unsigned FrameMax = 5;
  localparam int unsigned IdxW     = $clog2(FrameMax);
  localparam int unsigned LenW     = $clog2(FrameMax + 1);

  localparam logic [7:0] SyncByte = 8'h55;

  localparam logic [4:0] CmdRegRead  = 5'd9;
  localparam logic [4:0] CmdRegWrite = 5'd10;
  localparam logic [4:0] CmdBulkRead = 5'd11;

  localparam logic [5:0] RespRegRead  = 6'd3;
  localparam logic [5:0] RespRegWrite = 6'd0;
  localparam logic [5:0] RespBulkRead = 6'd45;

  localparam logic [LenW-1:0] LenRegRead  = LenW'(4);
  localparam logic [LenW-1:0] LenRegWrite = LenW'(5);
  localparam logic [LenW-1:0] LenBulkRead = LenW'(2);
  localparam logic [LenW-1:0] LenNone     = LenW'(0);

  typedef enum logic [1:0] {
    KIND_REG_READ  = 2'd0,
    KIND_REG_WRITE = 2'd1,
    KIND_BULK_READ = 2'd2
  } scf_kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_address;
    logic [7:0] write_data;
  } scf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [5:0] expected_response_bytes;
  } scf_out_t;

  // One fully built frame, byte 0 is sent first.
  typedef struct packed {
    logic [FrameMax-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
    logic [5:0]               resp;
  } scf_frame_t;

  // 8-bit add with end-around carry.
  function automatic logic [7:0] ea_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

// ===== rtl/sensor_uart_command_framer_top.sv =====
// Top level: sensor UART command framer.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is one
// command request (kind, register address, write data).
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat is one
// frame byte, in send order, with last_byte set on the final byte and the
// expected reply length repeated on every byte.
// Frames: register read 4 bytes, register write 5, bulk read 2; kind 3 is
// swallowed by the input register and yields no bytes.
// Path: an accepted request passes the input register, then the frame
// register, when the serializer is free, otherwise once the previous frame has left.
// Throughput: one byte per cycle while out_stall_i is low; the next frame
// follows the previous one with no gap through the single output port.
// The input register takes a new request while the previous frame drains.
// Stall: out_stall_i freezes the current byte; the input register then
// fills and in_stall_o rises until the serializer frees up.
// Reset: clears all valid state and sets the device address to 0.
// cfg_we_i / cfg_wdata_i write the device address; write only when idle.
module sensor_uart_command_framer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scf_pkg::scf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output scf_pkg::scf_out_t out_data_o
);
  import scf_pkg::*;

  logic [2:0] dev_addr_q;
  logic       frame_valid;
  scf_frame_t frame;
  logic       take;

  // Device address register, lands in command byte bits 7..5.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Stage 1: request register, frame bytes and checksum built from it.
  scf_frame_build u_build (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .dev_addr_i    (dev_addr_q),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .take_i        (take)
  );

  // Stage 2: frame register, one byte per output beat.
  scf_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ===== rtl/scf_frame_build.sv =====
// Input register and combinational frame assembly.
module scf_frame_build (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scf_pkg::scf_in_t    in_data_i,
  input  logic [2:0]          dev_addr_i,
  output logic                frame_valid_o,
  output scf_pkg::scf_frame_t frame_o,
  input  logic                take_i
);
  import scf_pkg::*;

  logic    in_vld_q, in_vld_d;
  scf_in_t in_q;
  logic    consumed;
  logic [7:0] cmd;
  logic [7:0] sum_rd, sum_wr;

  always_comb begin
    frame_o       = '0;
    frame_o.bytes[0] = SyncByte;
    cmd    = '0;
    sum_rd = ea_add(cmd, in_q.reg_address);
    sum_wr = '0;
    case (in_q.kind)
      KIND_REG_READ: begin
        cmd    = {dev_addr_i, CmdRegRead};
        sum_rd = ea_add(cmd, in_q.reg_address);
        frame_o.bytes[1] = cmd;
        frame_o.bytes[2] = in_q.reg_address;
        frame_o.bytes[3] = ~sum_rd;
        frame_o.len  = LenRegRead;
        frame_o.resp = RespRegRead;
      end
      KIND_REG_WRITE: begin
        cmd    = {dev_addr_i, CmdRegWrite};
        sum_rd = ea_add(cmd, in_q.reg_address);
        sum_wr = ea_add(sum_rd, in_q.write_data);
        frame_o.bytes[1] = cmd;
        frame_o.bytes[2] = in_q.reg_address;
        frame_o.bytes[3] = in_q.write_data;
        frame_o.bytes[4] = ~sum_wr;
        frame_o.len  = LenRegWrite;
        frame_o.resp = RespRegWrite;
      end
      KIND_BULK_READ: begin
        cmd    = {dev_addr_i, CmdBulkRead};
        frame_o.bytes[1] = cmd;
        frame_o.len  = LenBulkRead;
        frame_o.resp = RespBulkRead;
      end
      default: begin
        frame_o.len = LenNone;  // unused kind: dropped, no bytes
      end
    endcase
  end

  assign frame_valid_o = in_vld_q && (frame_o.len != LenNone);
  assign consumed      = in_vld_q && ((frame_o.len == LenNone) || take_i);
  assign in_stall_o    = in_vld_q && !consumed;

  always_comb begin
    in_vld_d = in_vld_q;
    if (consumed) begin
      in_vld_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

endmodule

// ===== rtl/scf_serializer.sv =====
// Frame register and byte serializer.
module scf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  scf_pkg::scf_frame_t frame_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scf_pkg::scf_out_t   out_data_o
);
  import scf_pkg::*;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  scf_frame_t      frame_q;
  logic            out_acc;
  logic            last;

  assign last    = (LenW'(idx_q) == (frame_q.len - LenW'(1)));
  assign out_acc = busy_q && !out_stall_i;
  assign take_o  = frame_valid_i && (!busy_q || (out_acc && last));

  assign out_valid_o                        = busy_q;
  assign out_data_o.frame_byte              = frame_q.bytes[idx_q];
  assign out_data_o.last_byte               = last;
  assign out_data_o.expected_response_bytes = frame_q.resp;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (out_acc) begin
      if (last) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
    if (take_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      frame_q <= frame_i;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (frame_q.len >= LenBulkRead) && (LenW'(idx_q) < frame_q.len))
    else $error("byte index outside loaded frame");

  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last |=> busy_q && (idx_q == $past(idx_q) + IdxW'(1)))
    else $error("index did not advance after mid-frame beat");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && out_stall_i |=> busy_q && $stable(idx_q) && $stable(frame_q))
    else $error("frame state moved while output stalled");
`endif

endmodule

// ===== test/tb.sv =====
// Testbench for the sensor UART command framer: directed and random requests, scoreboarded frame bytes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scf_pkg::*;

  // Request kind that the framer drops without sending any byte.
  localparam logic [1:0] KindUnused = 2'd3;

  // Run stops here no matter what; far above the slowest legal run.
  localparam int unsigned CycleLimit = 400000;
  // Long receiver hold-off, enough to back the framer up into its input.
  localparam int unsigned HoldCycles = 300;
  // Cycles a dropped request may still occupy the input path.
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ReportMax = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_e;

  // Predicts frame bytes from accepted requests and checks them in order.
  class frame_scoreboard;
    scf_out_t    pending[$];
    logic [2:0]  dev_addr;
    int unsigned mismatches;

    function new();
      dev_addr   = '0;
      mismatches = 0;
    endfunction

    function void set_address(logic [2:0] addr);
      dev_addr = addr;
    endfunction

    // Bytes 1..count folded with end-around carry, then inverted.
    function logic [7:0] frame_checksum(logic [4:0][7:0] frame, int count);
      logic [8:0] acc;
      acc = '0;
      for (int i = 1; i <= count; i++) begin
        acc = acc + {1'b0, frame[i]};
        if (acc > 9'd255) acc = acc - 9'd255;
      end
      return ~acc[7:0];
    endfunction

    function void note_request(scf_in_t req);
      logic [4:0][7:0] frame;
      int unsigned     len;
      logic [5:0]      resp;
      scf_out_t        beat;
      frame    = '0;
      frame[0] = SyncByte;
      case (req.kind)
        KIND_REG_READ: begin
          frame[1] = {dev_addr, CmdRegRead};
          frame[2] = req.reg_address;
          frame[3] = frame_checksum(frame, 2);
          len      = 4;
          resp     = RespRegRead;
        end
        KIND_REG_WRITE: begin
          frame[1] = {dev_addr, CmdRegWrite};
          frame[2] = req.reg_address;
          frame[3] = req.write_data;
          frame[4] = frame_checksum(frame, 3);
          len      = 5;
          resp     = RespRegWrite;
        end
        KIND_BULK_READ: begin
          frame[1] = {dev_addr, CmdBulkRead};
          len      = 2;
          resp     = RespBulkRead;
        end
        default: return;
      endcase
      for (int k = 0; k < len; k++) begin
        beat.frame_byte              = frame[k];
        beat.last_byte               = (k == len - 1);
        beat.expected_response_bytes = resp;
        pending.push_back(beat);
      end
    endfunction

    function void check_byte(scf_out_t got);
      scf_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected beat: byte %02h last %0b resp %0d, nothing pending",
                   got.frame_byte, got.last_byte, got.expected_response_bytes);
        return;
      end
      want = pending.pop_front();
      if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte ||
          got.expected_response_bytes !== want.expected_response_bytes) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("beat mismatch: expected byte %02h last %0b resp %0d,",
                   want.frame_byte, want.last_byte, want.expected_response_bytes,
                   " got byte %02h last %0b resp %0d",
                   got.frame_byte, got.last_byte, got.expected_response_bytes);
      end
    endfunction

    function void count_leftover();
      if (pending.size() != 0) begin
        $display("%0d frame bytes never sent", pending.size());
        mismatches += pending.size();
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [2:0] cfg_wdata = '0;
  logic     in_valid  = 1'b0;
  scf_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  scf_out_t out_data;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;

  frame_scoreboard sb;

  sensor_uart_command_framer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the framer hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // Output monitor: every accepted beat goes straight to the scoreboard.
  // Values read here are the ones that were stable at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_data);
  end

  // Receiver: stretches of different stall patterns, plus one long
  // hold-off when asked, so the framer fills and pushes back on input.
  initial begin
    stall_mode_e mode;
    int unsigned seg_len;
    int unsigned phase;
    phase = 0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      mode    = stall_mode_e'($urandom_range(0, 3));
      seg_len = $urandom_range(5, 60);
      repeat (seg_len) begin
        case (mode)
          STALL_NONE:      out_stall <= 1'b0;
          STALL_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:     out_stall <= ($urandom_range(0, 3) != 0);
          STALL_ALTERNATE: out_stall <= phase[0];
          default:         out_stall <= 1'b0;
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  function automatic scf_in_t make_request(logic [1:0] kind, logic [7:0] addr,
                                           logic [7:0] data);
    scf_in_t req;
    req.kind        = kind;
    req.reg_address = addr;
    req.write_data  = data;
    return req;
  endfunction

  // Offer one request and hold it until the framer takes the beat.
  // Valid stays high on return so back-to-back beats need no re-raise.
  task automatic push_request(scf_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Address register may only change with the framer idle; a dropped
  // request leaves nothing pending, so give it a few extra cycles.
  task automatic write_device_address(logic [2:0] addr);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_address(addr);
  endtask

  // Random requests in bursts; count covers real frames only, dropped
  // kinds ride along as noise.
  task automatic random_requests(int unsigned count);
    int unsigned sent;
    int unsigned burst_left;
    int unsigned gap;
    logic [1:0]  kind;
    logic [7:0]  addr;
    logic [7:0]  data;
    int unsigned pick;
    sent       = 0;
    burst_left = 0;
    while (sent < count) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      pick = $urandom_range(0, 19);
      kind = (pick == 0) ? KindUnused : 2'(pick % 3);
      addr = 8'($urandom_range(0, 255));
      data = 8'($urandom_range(0, 255));
      // Push operands to the rails now and then.
      if ($urandom_range(0, 7) == 0) addr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      push_request(make_request(kind, addr, data));
      burst_left--;
      if (kind != KindUnused) sent++;
    end
    stop_input();
  endtask

  initial begin
    logic [2:0] phase_addr[5];
    sb = new();
    phase_addr = '{3'd0, 3'd3, 3'd5, 3'd7, 3'($urandom_range(0, 7))};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset address 0.
    push_request(make_request(KIND_REG_READ, 8'h00, 8'h00));
    push_request(make_request(KIND_REG_READ, 8'hFF, 8'hFF));   // operand data ignored
    push_request(make_request(KIND_REG_READ, 8'hF6, 8'h00));   // sum hits 0xFF, checksum 0
    push_request(make_request(KIND_REG_WRITE, 8'h00, 8'h00));
    push_request(make_request(KIND_REG_WRITE, 8'hFF, 8'hFF));  // end-around carry
    push_request(make_request(KIND_REG_WRITE, 8'hAA, 8'h55));
    push_request(make_request(KIND_REG_WRITE, 8'h55, 8'hAA));
    push_request(make_request(KIND_BULK_READ, 8'hFF, 8'hFF));  // operands ignored
    push_request(make_request(KIND_BULK_READ, 8'h00, 8'h00));
    push_request(make_request(KindUnused, 8'h12, 8'h34));      // dropped, no bytes
    push_request(make_request(KIND_REG_WRITE, 8'hF6, 8'h00));
    stop_input();

    // Top address: command byte alone is large, so carries wrap often.
    write_device_address(3'd7);
    push_request(make_request(KIND_REG_READ, 8'hFF, 8'h00));
    push_request(make_request(KIND_REG_READ, 8'h00, 8'hFF));
    push_request(make_request(KIND_REG_WRITE, 8'hFF, 8'hFF));
    push_request(make_request(KIND_REG_WRITE, 8'h16, 8'h00));  // sum lands on 0x100
    push_request(make_request(KIND_REG_WRITE, 8'h80, 8'h7F));
    push_request(make_request(KindUnused, 8'hFF, 8'hFF));
    push_request(make_request(KIND_BULK_READ, 8'h5A, 8'hA5));
    stop_input();

    // Random phases, one address setting each; the first one also asks
    // the receiver for its long hold-off while requests keep coming.
    foreach (phase_addr[p]) begin
      write_device_address(phase_addr[p]);
      if (p == 0) hold_req = 1'b1;
      random_requests(45);
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.count_leftover();
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scf_pkg.sv
rtl/scf_frame_build.sv
rtl/scf_serializer.sv
rtl/sensor_uart_command_framer_top.sv
test/tb.sv
